// ===== design/bloom_matrix_port_lookup_core_macros.svh =====
// ----------------------------------------------------------------------------
// Bloom matrix port lookup: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BLOOM_MATRIX_PORT_LOOKUP_CORE_MACROS_SVH
`define BLOOM_MATRIX_PORT_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BMPL_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmpl: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BMPL_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmpl: next-cycle check failed");

`endif

// ===== design/bmpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpl_pkg
// Shared widths, field positions, opcodes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpl_pkg;

  localparam int SIZE_DEFAULT = 64;

  localparam int BYTE_W   = 8;
  localparam int VEC_W    = 64;
  localparam int S_DATA_W = BYTE_W + VEC_W;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = VEC_W;
  localparam int M_USER_W = 1;

  // s_tuser bit positions
  localparam int TUSER_OPCODE    = 0;
  localparam int TUSER_BLOCK_END = 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  // Matrix operation for the item being processed
  typedef struct packed {
    logic insert;
    logic query;
  } mx_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bmpl_colsel.sv =====
// ----------------------------------------------------------------------------
// bmpl_colsel
// Running per-block byte sum mod SIZE and the column set of the open key.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpl_colsel
  import bmpl_pkg::*;
#(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              block_end,
  input  logic              key_end,
  output logic [SIZE-1:0]   col_set
);

  localparam int SW = $clog2(SIZE);

  logic [SW-1:0]   block_sum;
  logic [SIZE-1:0] column_set;

  logic [SW-1:0]   byte_mod_tbl [2**BYTE_W];
  logic [SW-1:0]   byte_mod;
  logic [SW:0]     sum_raw;
  logic [SW-1:0]   sum_new;
  logic [SIZE-1:0] col_bit;

  // byte mod SIZE, constant table
  for (genvar i = 0; i < 2**BYTE_W; i++) begin : g_mod
    localparam logic [SW-1:0] MODV = SW'(i % SIZE);
    assign byte_mod_tbl[i] = MODV;
  end

  always_comb begin
    byte_mod = byte_mod_tbl[data_byte];
    sum_raw  = {1'b0, block_sum} + {1'b0, byte_mod};
    // both terms below SIZE, so one subtract is enough
    if (sum_raw >= (SW+1)'(SIZE)) begin
      sum_new = SW'(sum_raw - (SW+1)'(SIZE));
    end else begin
      sum_new = sum_raw[SW-1:0];
    end
    col_bit = {{(SIZE-1){1'b0}}, 1'b1} << sum_new;
    col_set = block_end ? (column_set | col_bit) : column_set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum  <= '0;
      column_set <= '0;
    end else if (advance) begin
      if (key_end) begin
        block_sum  <= '0;
        column_set <= '0;
      end else if (block_end) begin
        block_sum  <= '0;
        column_set <= col_set;
      end else begin
        block_sum  <= sum_new;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bmpl_matrix.sv =====
// ----------------------------------------------------------------------------
// bmpl_matrix
// SIZE x SIZE bit matrix: row per port, insert by OR, query by subset compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpl_matrix
  import bmpl_pkg::*;
#(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  mx_ctrl_t        ctrl,
  input  logic [SIZE-1:0] ports,
  input  logic [SIZE-1:0] col_set,
  output logic [SIZE-1:0] match
);

  logic [SIZE-1:0] rows [SIZE];

  // a row matches when it holds every selected column
  always_comb begin
    for (int r = 0; r < SIZE; r++) begin
      match[r] = ctrl.query && ((rows[r] & col_set) == col_set);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < SIZE; r++) begin
        rows[r] <= '0;
      end
    end else if (ctrl.insert) begin
      for (int r = 0; r < SIZE; r++) begin
        if (ports[r]) begin
          rows[r] <= rows[r] | col_set;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bloom_matrix_port_lookup_core.sv =====
// ----------------------------------------------------------------------------
// bloom_matrix_port_lookup_core
// Bloom filter matrix: hashed name bytes in, port match vector out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one key byte per transfer. tlast marks the last
//   byte of a key; tuser carries the opcode and the hash-block end flag.
//   The port vector is sampled only on the tlast transfer of an insert.
//   Each closed block's byte sum mod SIZE selects one column; bytes of a
//   block still open at key end are dropped.
//   Insert: ORs the column set into every row flagged in the port vector;
//   no result transfer.
//   Query: one master transfer carrying the match vector (tdata) and the
//   found flag (tuser). An empty column set matches every row.
//   Result path: a query's tlast transfer passes the input register, then the
//   result register, which drives m_tvalid. Throughput: one transfer per cycle
//   unless a receiver stall holds a query result, set by the single pass from
//   the input register through the parallel row compare to the result register.
//   Receiver stall: the result register holds; the input register keeps
//   taking bytes until a second query result would need the busy slot.
//   Reset: synchronous; clears the matrix, running sums and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bloom_matrix_port_lookup_core_macros.svh"

module bloom_matrix_port_lookup_core
  import bmpl_pkg::*;
#(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // slave stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // data_byte[7:0], port_vector[71:8]
  input  logic [S_USER_W-1:0] s_tuser,  // opcode[0], block_end[1]
  input  logic                s_tlast,  // key_end
  // master stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // match_vector[63:0]
  output logic [M_USER_W-1:0] m_tuser   // found[0]
);

  localparam logic [VEC_W-1:0] ROW_MASK = VEC_W'((65'd1 << SIZE) - 65'd1);

  // input register
  logic              in_valid;
  opcode_t           in_opcode;
  logic [BYTE_W-1:0] in_byte;
  logic              in_bend;
  logic              in_kend;
  logic [VEC_W-1:0]  in_ports;

  // result register
  logic              out_valid;
  logic [VEC_W-1:0]  out_match;
  logic              out_found;

  logic              s_xfer;
  logic              out_free;
  logic              produces;
  logic              fire;
  mx_ctrl_t          mx_ctrl;
  logic [SIZE-1:0]   col_set;
  logic [SIZE-1:0]   match;

  // a query at key end needs the result slot; everything else just flows
  always_comb begin
    produces      = in_kend && (in_opcode == OP_QUERY);
    out_free      = !out_valid || m_tready;
    fire          = in_valid && (!produces || out_free);
    s_tready      = !in_valid || fire;
    s_xfer        = s_tvalid && s_tready;
    mx_ctrl.insert = fire && in_kend && (in_opcode == OP_INSERT);
    mx_ctrl.query  = fire && produces;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_opcode <= opcode_t'(s_tuser[TUSER_OPCODE]);
      in_bend   <= s_tuser[TUSER_BLOCK_END];
      in_kend   <= s_tlast;
      in_byte   <= s_tdata[BYTE_W-1:0];
      in_ports  <= s_tdata[S_DATA_W-1:BYTE_W];
    end
  end

  bmpl_colsel #(
    .SIZE(SIZE)
  ) u_colsel (
    .clk       (clk),
    .rst       (rst),
    .advance   (fire),
    .data_byte (in_byte),
    .block_end (in_bend),
    .key_end   (in_kend),
    .col_set   (col_set)
  );

  bmpl_matrix #(
    .SIZE(SIZE)
  ) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mx_ctrl),
    .ports   (in_ports[SIZE-1:0]),
    .col_set (col_set),
    .match   (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mx_ctrl.query) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mx_ctrl.query) begin
      out_match <= VEC_W'(match);
      out_found <= |match;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_match;
  assign m_tuser[0] = out_found;

  // checks
  `BMPL_ASSERT_NEXT(a_query_gives_result, clk, rst, mx_ctrl.query, m_tvalid)
  `BMPL_ASSERT_IMPL(a_found_vs_match, clk, rst, m_tvalid, m_tuser[0] == (m_tdata != '0))
  `BMPL_ASSERT_IMPL(a_match_in_range, clk, rst, m_tvalid, (m_tdata & ~ROW_MASK) == '0)
  `BMPL_ASSERT_IMPL(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !mx_ctrl.query)

endmodule

`default_nettype wire
